// ===== hdl/gf2rrb_pkg.sv =====
package gf2rrb_pkg;

	localparam int COL_W       = 10;
	localparam int PRIME_W     = 32;
	localparam int CNT_REG_W   = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int MAX_ODD_DEF    = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_RATIONAL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALGEBRAIC = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_RATIONAL  = 2'd1,
		OP_ALGEBRAIC = 2'd2,
		OP_END       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_TOGGLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                operation;
		logic [COL_W-1:0]   column;
		logic [PRIME_W-1:0] prime;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0] odd_column;
		logic             last;
		logic             empty_res;
		logic             truncated;
	} res_t;

endpackage

// ===== hdl/gf2rrb_ram.sv =====
module gf2rrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/gf2_relation_row_builder.sv =====
// Builds one sparse GF(2) row per relation from a table of primes held in a
// single-port-read memory. A load request writes its prime into the table at
// its column if the column lies inside the table. A rational factor scans the
// rational columns from the top down and an algebraic factor scans the
// algebraic columns from the bottom up, one table entry per cycle, and toggles
// the parity bit of the first matching entry. An end-of-relation request
// sweeps the whole parity memory one entry per cycle while the result side
// does not stall, clearing as it goes. Results are held in an output
// register, so the next request is taken while the last result waits. After
// reset a clearing pass over every parity entry runs before the first request
// is taken; configuration writes are accepted at any time.
module gf2_relation_row_builder #(
	parameter int TABLE_SIZE = gf2rrb_pkg::TABLE_SIZE_DEF,
	parameter int MAX_ODD    = gf2rrb_pkg::MAX_ODD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  gf2rrb_pkg::req_t                     request,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output gf2rrb_pkg::res_t                     result,
	input  logic                                 cfg_we,
	input  logic [gf2rrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gf2rrb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import gf2rrb_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int NW    = $clog2(MAX_ODD + 1);
	localparam int EXT_W = (CNT_W > CNT_REG_W + 1) ? CNT_W : CNT_REG_W + 1;
	localparam int CEX_W = (CNT_W > COL_W) ? CNT_W : COL_W;

	state_t state_q, state_d;

	logic [CNT_REG_W-1:0] rc_q, ac_q;
	logic [PRIME_W-1:0]   val_q;
	logic                 down_q;
	logic [CNT_W-1:0]     pos_q, lim_q, scan_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     addr_s1, hit_q, stg_col_q;
	logic [NW-1:0]        n_q;
	logic                 more_q, stg_v_q, res_valid_q;
	res_t                 res_q;

	logic [EXT_W-1:0] rat_w, sum_w, ts_w;
	logic [CNT_W-1:0] rat_end, alg_end;
	logic [CEX_W-1:0] col_ext;
	logic             load_ok, req_fire, out_free;
	logic             srch_issue, hit, take, push_mid, stall, scan_end, scan_issue;
	logic             fin_push;
	logic [IDX_W-1:0] srch_addr;

	logic                 prime_we, prime_re;
	logic [IDX_W-1:0]     prime_waddr, prime_raddr;
	logic [PRIME_W-1:0]   prime_rdata;
	logic                 par_we, par_re, par_wdata, par_rdata;
	logic [IDX_W-1:0]     par_waddr, par_raddr;

	gf2rrb_ram #(.WIDTH(PRIME_W), .DEPTH(TABLE_SIZE)) u_prime_ram (
		.clk   (clk),
		.we    (prime_we),
		.waddr (prime_waddr),
		.wdata (request.prime),
		.re    (prime_re),
		.raddr (prime_raddr),
		.rdata (prime_rdata)
	);

	gf2rrb_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_parity_ram (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.re    (par_re),
		.raddr (par_raddr),
		.rdata (par_rdata)
	);

	assign rat_w   = EXT_W'(rc_q);
	assign sum_w   = EXT_W'(rc_q) + EXT_W'(ac_q);
	assign ts_w    = EXT_W'(TABLE_SIZE);
	assign rat_end = CNT_W'((rat_w < ts_w) ? rat_w : ts_w);
	assign alg_end = CNT_W'((sum_w < ts_w) ? sum_w : ts_w);

	assign col_ext  = CEX_W'(request.column);
	assign load_ok  = col_ext < CEX_W'(TABLE_SIZE);
	assign req_fire = req_valid && req_ready;
	assign out_free = !res_valid_q || res_ready;

	assign srch_issue = down_q ? (pos_q != '0) : (pos_q < lim_q);
	assign srch_addr  = down_q ? IDX_W'(pos_q - 1'b1) : IDX_W'(pos_q);
	assign hit        = pend_s1 && (prime_rdata == val_q);

	// one-behind staging: a found column leaves once the next one shows up, or as the last result at the end
	assign take       = pend_s1 && par_rdata && (n_q < NW'(MAX_ODD));
	assign push_mid   = (state_q == ST_SCAN) && take && stg_v_q;
	assign stall      = push_mid && !out_free;
	assign scan_end   = scan_q == CNT_W'(TABLE_SIZE);
	assign scan_issue = !stall && !scan_end;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (scan_q == CNT_W'(TABLE_SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					unique case (request.operation) inside
						OP_LOAD:                   state_d = ST_IDLE;
						OP_RATIONAL, OP_ALGEBRAIC: state_d = ST_SEARCH;
						OP_END:                    state_d = ST_SCAN;
						default:                   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = ST_TOGGLE;
				end else if (!srch_issue && !pend_s1) begin
					state_d = ST_IDLE;
				end
			end
			ST_TOGGLE: state_d = ST_IDLE;
			ST_SCAN: begin
				if (!pend_s1 && scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		prime_we    = 1'b0;
		prime_waddr = IDX_W'(col_ext);
		prime_re    = 1'b0;
		prime_raddr = srch_addr;
		par_we      = 1'b0;
		par_waddr   = addr_s1;
		par_wdata   = 1'b0;
		par_re      = 1'b0;
		par_raddr   = IDX_W'(scan_q);
		fin_push    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				par_we    = 1'b1;
				par_waddr = IDX_W'(scan_q);
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				prime_we  = req_valid && (request.operation == OP_LOAD) && load_ok;
			end
			ST_SEARCH: begin
				prime_re = srch_issue && !hit;
				if (hit) begin
					par_re    = 1'b1;
					par_raddr = addr_s1;
				end
			end
			ST_TOGGLE: begin
				par_we    = 1'b1;
				par_waddr = hit_q;
				par_wdata = !par_rdata;
			end
			ST_SCAN: begin
				par_re = scan_issue;
				par_we = pend_s1 && !stall;
			end
			ST_FINISH: fin_push = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rc_q        <= '0;
			ac_q        <= '0;
			down_q      <= 1'b0;
			pos_q       <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			n_q         <= '0;
			more_q      <= 1'b0;
			stg_v_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RATIONAL:  rc_q <= cfg_data;
					CFG_ALGEBRAIC: ac_q <= cfg_data;
					default: ;
				endcase
			end
			pend_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					scan_q <= (scan_q == CNT_W'(TABLE_SIZE - 1)) ? '0 : scan_q + 1'b1;
				end
				ST_IDLE: begin
					if (req_fire) begin
						down_q  <= request.operation == OP_RATIONAL;
						pos_q   <= rat_end;
						scan_q  <= '0;
						n_q     <= '0;
						more_q  <= 1'b0;
						stg_v_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					pend_s1 <= srch_issue && !hit;
					if (srch_issue && !hit) begin
						pos_q <= down_q ? pos_q - 1'b1 : pos_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (stall) begin
						pend_s1 <= pend_s1;
					end else begin
						pend_s1 <= scan_issue;
						if (scan_issue) begin
							scan_q <= scan_q + 1'b1;
						end
						if (pend_s1 && par_rdata) begin
							if (take) begin
								stg_v_q <= 1'b1;
								n_q     <= n_q + 1'b1;
							end else begin
								more_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
			if ((push_mid && !stall) || fin_push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_fire) begin
			val_q <= request.prime;
			lim_q <= alg_end;
		end
		if (state_q == ST_SEARCH || (state_q == ST_SCAN && !stall)) begin
			addr_s1 <= (state_q == ST_SEARCH) ? srch_addr : IDX_W'(scan_q);
		end
		if (state_q == ST_SEARCH && hit) begin
			hit_q <= addr_s1;
		end
		if (push_mid && !stall) begin
			res_q <= '{odd_column: COL_W'(stg_col_q), last: 1'b0,
				empty_res: 1'b0, truncated: 1'b0};
		end else if (fin_push) begin
			if (stg_v_q) begin
				res_q <= '{odd_column: COL_W'(stg_col_q), last: 1'b1,
					empty_res: 1'b0, truncated: more_q};
			end else begin
				res_q <= '{odd_column: '0, last: 1'b1, empty_res: 1'b1,
					truncated: 1'b0};
			end
		end
		if (state_q == ST_SCAN && take && !stall) begin
			stg_col_q <= addr_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign result    = res_q;

endmodule

// ===== hdl/gf2rrb_checker.sv =====
module gf2rrb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic                                 req_ready,
	input  gf2rrb_pkg::req_t                     request,
	input  logic                                 res_valid,
	input  logic                                 res_ready,
	input  gf2rrb_pkg::res_t                     result
);

	import gf2rrb_pkg::*;

	logic             in_row_q;
	logic [COL_W-1:0] prev_col_q;
	logic             res_fire;

	assign res_fire = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= 1'b0;
			prev_col_q <= '0;
		end else if (res_fire) begin
			in_row_q   <= !result.last;
			prev_col_q <= result.odd_column;
		end
	end

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(request))
		else $error("request dropped or changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result.empty_res |-> result.last && result.odd_column == '0
			&& !result.truncated && !in_row_q)
		else $error("empty row result malformed");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result.truncated |-> result.last && !result.empty_res)
		else $error("truncated flag off the last result");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && in_row_q |-> result.odd_column > prev_col_q)
		else $error("odd columns not ascending");

endmodule

bind gf2_relation_row_builder gf2rrb_checker u_checker (.*);
